// ===== src/voxel_chunk_face_culler_top_defines.svh =====
// Assertion macros shared by the face culler RTL.
// No dependencies; taken in by the controller and the datapath.
`ifndef VOXEL_CHUNK_FACE_CULLER_TOP_DEFINES_SVH
`define VOXEL_CHUNK_FACE_CULLER_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during rst
`define VCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define VCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VCF_ASSERT_NOW(lbl, ante, cons, msg)
`define VCF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/vcf_pkg.sv =====
// Shared types and constants of the voxel face culler.
// No dependencies; used by the controller, datapath and top level.
package vcf_pkg;

  localparam int COUNT_W  = 15;
  localparam int NUM_DIRS = 6;

  // input actions
  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_MESH  = 2'd2,
    ACT_NOP   = 2'd3
  } vcf_action_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_READ = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_FACE = 2'd2,
    KIND_NONE = 2'd3
  } vcf_kind_t;

  // face directions
  localparam logic [2:0] DIR_YP = 3'd0;
  localparam logic [2:0] DIR_YN = 3'd1;
  localparam logic [2:0] DIR_XP = 3'd2;
  localparam logic [2:0] DIR_XN = 3'd3;
  localparam logic [2:0] DIR_ZP = 3'd4;
  localparam logic [2:0] DIR_ZN = 3'd5;

  // fetch slots: centre voxel, then one per direction
  localparam logic [2:0] SLOT_CENTRE = 3'd0;
  localparam logic [2:0] SLOT_YP     = 3'd1;
  localparam logic [2:0] SLOT_YN     = 3'd2;
  localparam logic [2:0] SLOT_XP     = 3'd3;
  localparam logic [2:0] SLOT_XN     = 3'd4;
  localparam logic [2:0] SLOT_ZP     = 3'd5;
  localparam logic [2:0] SLOT_ZN     = 3'd6;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_READ_OUT,
    ST_WRITE,
    ST_FETCH,
    ST_EVAL,
    ST_EMIT
  } vcf_state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic do_read;
    logic out_read;
    logic do_write;
    logic fetch;
    logic fetch_tail;
    logic emit;
  } vcf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic fetch_done;
    logic emit_last;
  } vcf_status_t;

endpackage

// ===== src/vcf_controller.sv =====
// Sequencing state machine of the voxel face culler.
// Depends on vcf_pkg and the assertion macro header.
`include "voxel_chunk_face_culler_top_defines.svh"

module vcf_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           action,
  input  vcf_pkg::vcf_status_t status,
  output vcf_pkg::vcf_cmd_t    cmd,
  output logic                 busy
);
  import vcf_pkg::*;

  vcf_state_t state;
  vcf_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          unique case (action)
            ACT_READ:  state_next = ST_READ;
            ACT_WRITE: state_next = ST_WRITE;
            ACT_MESH:  state_next = ST_FETCH;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ:     state_next = ST_READ_OUT;
      ST_READ_OUT: state_next = ST_IDLE;
      ST_WRITE:    state_next = ST_IDLE;
      ST_FETCH: begin
        if (status.fetch_done) state_next = ST_EVAL;
      end
      ST_EVAL:     state_next = ST_EMIT;
      ST_EMIT: begin
        if (status.emit_last) state_next = ST_IDLE;
      end
      default:     state_next = ST_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_CLEAR:    cmd.clear_step = 1'b1;
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_READ:     cmd.do_read    = 1'b1;
      ST_READ_OUT: cmd.out_read   = 1'b1;
      ST_WRITE:    cmd.do_write   = 1'b1;
      ST_FETCH:    cmd.fetch      = 1'b1;
      ST_EVAL:     cmd.fetch_tail = 1'b1;
      ST_EMIT:     cmd.emit       = 1'b1;
      default:     cmd            = '0;
    endcase
  end

  // faces only follow a completed neighbour fetch
  `VCF_ASSERT_NOW(a_emit_after_eval, state == ST_EMIT, $past(state) == ST_EVAL || $past(state) == ST_EMIT, "emit entered without fetch")
  // the clearing pass only ever leaves to idle
  `VCF_ASSERT_NEXT(a_clear_exit, state == ST_CLEAR, state == ST_CLEAR || state == ST_IDLE, "bad exit from clearing pass")

endmodule

// ===== src/vcf_datapath.sv =====
// Voxel store, scan position, face counter and result registers.
// Depends on vcf_pkg and the assertion macro header.
`include "voxel_chunk_face_culler_top_defines.svh"

module vcf_datapath #(
  parameter int SIDE       = 16,
  parameter int BLOCK_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  vcf_pkg::vcf_cmd_t    cmd,
  output vcf_pkg::vcf_status_t status,
  input  logic signed [5:0]    pos_x,
  input  logic signed [5:0]    pos_y,
  input  logic signed [5:0]    pos_z,
  input  logic [7:0]           block_value,
  output logic                 result_strobe,
  output logic [1:0]           result_kind,
  output logic [7:0]           read_value,
  output logic [2:0]           face_dir,
  output logic [3:0]           face_x,
  output logic [3:0]           face_y,
  output logic [3:0]           face_z,
  output logic [14:0]          face_index,
  output logic [14:0]          face_total,
  output logic                 scan_done,
  output logic                 last,
  output logic                 dirty_flag
);
  import vcf_pkg::*;

  localparam int CW    = $clog2(SIDE);
  localparam int CELLS = SIDE * SIDE * SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam logic [CW-1:0] MAXC      = CW'(SIDE - 1);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                               input logic [CW-1:0] y,
                                               input logic [CW-1:0] z);
    cell_addr = AW'((int'(x) * SIDE + int'(y)) * SIDE + int'(z));
  endfunction

  function automatic logic [2:0] count6(input logic [NUM_DIRS-1:0] m);
    logic [2:0] c;
    c = '0;
    for (int i = 0; i < NUM_DIRS; i++) c = c + 3'(m[i]);
    count6 = c;
  endfunction

  // store
  logic [BLOCK_BITS-1:0] mem [CELLS];
  logic [BLOCK_BITS-1:0] rdata;
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [BLOCK_BITS-1:0] mem_wdata;

  // control registers
  logic [AW-1:0]      clr_addr;
  logic [CW-1:0]      scan_x, scan_y, scan_z;
  logic [COUNT_W-1:0] face_counter;
  logic               dirty;
  logic [2:0]         fetch_k;

  // transaction payload
  logic [CW-1:0]         act_x, act_y, act_z;
  logic                  act_ok;
  logic [BLOCK_BITS-1:0] act_value;
  logic [AW-1:0]         act_addr;
  logic                  in_ok;

  // neighbour evaluation
  logic                oor_d;
  logic                centre_solid;
  logic [NUM_DIRS-1:0] vis_mask;
  logic [CW-1:0]       fx, fy, fz;
  logic                f_ok;
  logic [AW-1:0]       f_addr;
  logic                eval_en;
  logic [2:0]          eval_dir;
  logic                eval_air;

  // emission
  logic [NUM_DIRS-1:0] emask, emask_rest, pick_bit;
  logic [2:0]          pick;
  logic                emit_last;
  logic                scan_end;
  logic [COUNT_W-1:0]  total;
  logic [CW-1:0]       scan_x_next, scan_y_next, scan_z_next;

  // result next values
  logic                res_valid;
  logic [1:0]          res_kind;
  logic [7:0]          res_read;
  logic [2:0]          res_dir;
  logic [3:0]          res_x, res_y, res_z;
  logic [COUNT_W-1:0]  res_index, res_total;
  logic                res_done, res_last, res_dirty;

  // coordinate range check of the incoming transaction
  always_comb begin
    in_ok = !pos_x[5] && int'(pos_x[4:0]) < SIDE &&
            !pos_y[5] && int'(pos_y[4:0]) < SIDE &&
            !pos_z[5] && int'(pos_z[4:0]) < SIDE;
  end

  assign act_addr = cell_addr(act_x, act_y, act_z);

  // fetch slot decode: centre then six neighbours
  always_comb begin
    fx   = scan_x;
    fy   = scan_y;
    fz   = scan_z;
    f_ok = 1'b1;
    unique case (fetch_k)
      SLOT_CENTRE: f_ok = 1'b1;
      SLOT_YP: begin fy = scan_y + 1'b1; f_ok = (scan_y != MAXC); end
      SLOT_YN: begin fy = scan_y - 1'b1; f_ok = (scan_y != '0);   end
      SLOT_XP: begin fx = scan_x + 1'b1; f_ok = (scan_x != MAXC); end
      SLOT_XN: begin fx = scan_x - 1'b1; f_ok = (scan_x != '0);   end
      SLOT_ZP: begin fz = scan_z + 1'b1; f_ok = (scan_z != MAXC); end
      SLOT_ZN: begin fz = scan_z - 1'b1; f_ok = (scan_z != '0);   end
      default: f_ok = 1'b0;
    endcase
    f_addr = cell_addr(fx, fy, fz);
  end

  // single memory port
  always_comb begin
    mem_we    = cmd.clear_step || (cmd.do_write && act_ok);
    mem_wdata = cmd.clear_step ? '0 : act_value;
    if (cmd.clear_step) begin
      mem_addr = clr_addr;
    end else if (cmd.fetch) begin
      mem_addr = f_addr;
    end else begin
      mem_addr = act_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  // evaluation of the slot fetched last cycle
  assign eval_en  = (cmd.fetch && fetch_k != SLOT_CENTRE) || cmd.fetch_tail;
  assign eval_dir = fetch_k - 3'd2;
  assign eval_air = oor_d || (rdata == '0);

  // lowest visible face first
  always_comb begin
    emask = centre_solid ? vis_mask : '0;
    pick  = DIR_YP;
    for (int i = NUM_DIRS - 1; i >= 0; i--) begin
      if (emask[i]) pick = 3'(i);
    end
    pick_bit   = NUM_DIRS'(1) << pick;
    emask_rest = emask & ~pick_bit;
    emit_last  = (emask_rest == '0);
    total      = face_counter + COUNT_W'(count6(emask));
    scan_end   = (scan_x == MAXC) && (scan_y == MAXC) && (scan_z == MAXC);
  end

  // scan order: z innermost, x outermost
  always_comb begin
    scan_x_next = scan_x;
    scan_y_next = scan_y;
    scan_z_next = scan_z + 1'b1;
    if (scan_z == MAXC) begin
      scan_z_next = '0;
      scan_y_next = scan_y + 1'b1;
      if (scan_y == MAXC) begin
        scan_y_next = '0;
        scan_x_next = (scan_x == MAXC) ? '0 : scan_x + 1'b1;
      end
    end
  end

  assign status.clear_done = (clr_addr == LAST_CELL);
  assign status.fetch_done = (fetch_k == SLOT_ZN);
  assign status.emit_last  = emit_last;

  // result formation
  always_comb begin
    res_valid = cmd.out_read || cmd.do_write || cmd.emit;
    res_kind  = KIND_READ;
    res_read  = '0;
    res_dir   = DIR_YP;
    res_x     = '0;
    res_y     = '0;
    res_z     = '0;
    res_index = '0;
    res_total = '0;
    res_done  = 1'b0;
    res_last  = 1'b1;
    res_dirty = dirty;
    if (cmd.out_read) begin
      res_read = act_ok ? 8'(rdata) : 8'd0;
    end else if (cmd.do_write) begin
      res_kind  = KIND_ACK;
      res_dirty = act_ok || dirty;
    end else if (cmd.emit) begin
      res_kind  = (emask == '0) ? KIND_NONE : KIND_FACE;
      res_dir   = (emask == '0) ? DIR_YP : pick;
      res_x     = 4'(scan_x);
      res_y     = 4'(scan_y);
      res_z     = 4'(scan_z);
      res_index = (emask == '0) ? '0 : face_counter;
      res_total = scan_end ? total : '0;
      res_done  = scan_end;
      res_last  = emit_last;
      res_dirty = scan_end ? 1'b0 : dirty;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr      <= '0;
      scan_x        <= '0;
      scan_y        <= '0;
      scan_z        <= '0;
      face_counter  <= '0;
      dirty         <= 1'b0;
      fetch_k       <= SLOT_CENTRE;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= res_valid;
      if (cmd.clear_step) clr_addr <= clr_addr + 1'b1;
      if (cmd.capture) begin
        fetch_k <= SLOT_CENTRE;
      end else if (cmd.fetch) begin
        fetch_k <= fetch_k + 3'd1;
      end
      if (cmd.do_write && act_ok) dirty <= 1'b1;
      if (cmd.emit) begin
        if (emit_last && scan_end) begin
          face_counter <= '0;
          dirty        <= 1'b0;
        end else if (emask != '0) begin
          face_counter <= face_counter + 1'b1;
        end
        if (emit_last) begin
          scan_x <= scan_x_next;
          scan_y <= scan_y_next;
          scan_z <= scan_z_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_x     <= CW'(pos_x[4:0]);
      act_y     <= CW'(pos_y[4:0]);
      act_z     <= CW'(pos_z[4:0]);
      act_ok    <= in_ok;
      act_value <= BLOCK_BITS'(block_value);
    end
    if (cmd.fetch) oor_d <= !f_ok;
    if (eval_en) begin
      if (fetch_k == SLOT_YP) begin
        centre_solid <= (rdata != '0);
      end else begin
        vis_mask[eval_dir] <= eval_air;
      end
    end
    if (cmd.emit) vis_mask <= emask_rest;
    result_kind <= res_kind;
    read_value  <= res_read;
    face_dir    <= res_dir;
    face_x      <= res_x;
    face_y      <= res_y;
    face_z      <= res_z;
    face_index  <= res_index;
    face_total  <= res_total;
    scan_done   <= res_done;
    last        <= res_last;
    dirty_flag  <= res_dirty;
  end

  // the final voxel leaves the scan at its start
  `VCF_ASSERT_NOW(a_scan_wrap, result_strobe && last && scan_done, face_counter == '0 && scan_x == '0 && scan_y == '0 && scan_z == '0, "scan did not restart")
  // a voxel without faces yields exactly one result
  `VCF_ASSERT_NOW(a_none_is_last, result_strobe && result_kind == KIND_NONE, last, "faceless voxel result not last")
  // a finished scan always leaves the store clean
  `VCF_ASSERT_NOW(a_done_clean, result_strobe && scan_done, !dirty_flag, "dirty after completed scan")

endmodule

// ===== src/voxel_chunk_face_culler_top.sv =====
// Voxel face culler: 16x16x16 block store with read, write and mesh scan.
// A read passes through READ and READ_OUT, a write through WRITE, and a mesh
// step through FETCH, EVAL and EMIT; busy is low only in IDLE. The one
// store port sets the mesh step at seven reads. Results come one per cycle,
// unstallable. After rst a clearing pass writes air to SIDE^3 entries,
// busy high throughout; synchronous active-high reset.
module voxel_chunk_face_culler_top #(
  parameter int SIDE       = 16,
  parameter int BLOCK_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        action,
  input  logic signed [5:0] pos_x,
  input  logic signed [5:0] pos_y,
  input  logic signed [5:0] pos_z,
  input  logic [7:0]        block_value,
  output logic              result_strobe,
  output logic [1:0]        result_kind,
  output logic [7:0]        read_value,
  output logic [2:0]        face_dir,
  output logic [3:0]        face_x,
  output logic [3:0]        face_y,
  output logic [3:0]        face_z,
  output logic [14:0]       face_index,
  output logic [14:0]       face_total,
  output logic              scan_done,
  output logic              last,
  output logic              dirty_flag
);
  import vcf_pkg::*;

  vcf_cmd_t    cmd;
  vcf_status_t status;

  // sequencer
  vcf_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // store and result path
  vcf_datapath #(
    .SIDE       (SIDE),
    .BLOCK_BITS (BLOCK_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .block_value   (block_value),
    .result_strobe (result_strobe),
    .result_kind   (result_kind),
    .read_value    (read_value),
    .face_dir      (face_dir),
    .face_x        (face_x),
    .face_y        (face_y),
    .face_z        (face_z),
    .face_index    (face_index),
    .face_total    (face_total),
    .scan_done     (scan_done),
    .last          (last),
    .dirty_flag    (dirty_flag)
  );

endmodule
